>>> sv/mbf_pkg.sv
// ----------------------------------------------------------------------------
// mbf_pkg
// Shared widths, register indexes, control struct and modular helper steps.
// ----------------------------------------------------------------------------
`default_nettype none
package mbf_pkg;

  localparam int W   = 62;
  localparam int Lat = 2 * W + 3;

  localparam logic [1:0] RegModulus = 2'd0;
  localparam logic [1:0] RegImag    = 2'd1;
  localparam logic [1:0] RegHalf    = 2'd2;

  typedef logic [W-1:0] res_t;

  typedef struct packed {
    logic vld;
    logic inv;
    logic last;
  } ctl_t;

  // one restoring remainder step: (2r + b) mod q, r < q
  function automatic res_t red_step(res_t r, logic b, res_t q);
    logic [W:0] t;
    t = {r, b};
    if (t >= {1'b0, q}) t = t - {1'b0, q};
    return t[W-1:0];
  endfunction

  // one double-and-add step: 2r (+ x) mod q
  function automatic res_t dbl_add(res_t r, logic b, res_t x, res_t q);
    logic [W:0] t;
    logic [W:0] s;
    res_t       res;
    t = {r, 1'b0};
    if (t >= {1'b0, q}) t = t - {1'b0, q};
    s = {1'b0, t[W-1:0]} + {1'b0, x};
    if (s >= {1'b0, q}) s = s - {1'b0, q};
    res = b ? s[W-1:0] : t[W-1:0];
    return res;
  endfunction

  function automatic res_t add_mod(res_t x, res_t y, res_t q);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, q}) s = s - {1'b0, q};
    return s[W-1:0];
  endfunction

  function automatic res_t sub_mod(res_t x, res_t y, res_t q);
    logic [W:0] s;
    if (x >= y) s = {1'b0, x} - {1'b0, y};
    else s = {1'b0, x} + {1'b0, q} - {1'b0, y};
    return s[W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> sv/mbf_reduce.sv
// ----------------------------------------------------------------------------
// mbf_reduce
// Three-lane remainder pipeline, one dividend bit per stage, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none
module mbf_reduce (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire mbf_pkg::ctl_t ctl_i,
  input  wire mbf_pkg::res_t q_i,
  input  wire mbf_pkg::res_t a_i,
  input  wire mbf_pkg::res_t b_i,
  input  wire mbf_pkg::res_t k_i,
  output mbf_pkg::ctl_t      ctl_o,
  output mbf_pkg::res_t      q_o,
  output mbf_pkg::res_t      a_o,
  output mbf_pkg::res_t      b_o,
  output mbf_pkg::res_t      k_o
);

  localparam int W = mbf_pkg::W;

  mbf_pkg::ctl_t ctl_r [1:W];
  mbf_pkg::res_t q_r   [1:W];
  mbf_pkg::res_t va_r  [1:W];
  mbf_pkg::res_t vb_r  [1:W];
  mbf_pkg::res_t vk_r  [1:W];
  mbf_pkg::res_t ra_r  [1:W];
  mbf_pkg::res_t rb_r  [1:W];
  mbf_pkg::res_t rk_r  [1:W];

  for (genvar j = 0; j < W; j++) begin : g_stg
    mbf_pkg::ctl_t c_s;
    mbf_pkg::res_t q_s, va_s, vb_s, vk_s, ra_s, rb_s, rk_s;
    if (j == 0) begin : g_first
      assign c_s  = ctl_i;
      assign q_s  = q_i;
      assign va_s = a_i;
      assign vb_s = b_i;
      assign vk_s = k_i;
      assign ra_s = '0;
      assign rb_s = '0;
      assign rk_s = '0;
    end else begin : g_mid
      assign c_s  = ctl_r[j];
      assign q_s  = q_r[j];
      assign va_s = va_r[j];
      assign vb_s = vb_r[j];
      assign vk_s = vk_r[j];
      assign ra_s = ra_r[j];
      assign rb_s = rb_r[j];
      assign rk_s = rk_r[j];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[j+1] <= '0;
      end else begin
        ctl_r[j+1] <= c_s;
      end
      q_r[j+1]  <= q_s;
      va_r[j+1] <= va_s;
      vb_r[j+1] <= vb_s;
      vk_r[j+1] <= vk_s;
      ra_r[j+1] <= mbf_pkg::red_step(ra_s, va_s[W-1-j], q_s);
      rb_r[j+1] <= mbf_pkg::red_step(rb_s, vb_s[W-1-j], q_s);
      rk_r[j+1] <= mbf_pkg::red_step(rk_s, vk_s[W-1-j], q_s);
    end
  end

  assign ctl_o = ctl_r[W];
  assign q_o   = q_r[W];
  assign a_o   = ra_r[W];
  assign b_o   = rb_r[W];
  assign k_o   = rk_r[W];

endmodule
`default_nettype wire

>>> sv/mbf_mulmod.sv
// ----------------------------------------------------------------------------
// mbf_mulmod
// Modular multiply pipeline, one multiplier bit per stage, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none
module mbf_mulmod (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire mbf_pkg::ctl_t ctl_i,
  input  wire mbf_pkg::res_t q_i,
  input  wire mbf_pkg::res_t aux_i,
  input  wire mbf_pkg::res_t x_i,
  input  wire mbf_pkg::res_t y_i,
  output mbf_pkg::ctl_t      ctl_o,
  output mbf_pkg::res_t      q_o,
  output mbf_pkg::res_t      aux_o,
  output mbf_pkg::res_t      p_o
);

  localparam int W = mbf_pkg::W;

  mbf_pkg::ctl_t ctl_r [1:W];
  mbf_pkg::res_t q_r   [1:W];
  mbf_pkg::res_t aux_r [1:W];
  mbf_pkg::res_t x_r   [1:W];
  mbf_pkg::res_t y_r   [1:W];
  mbf_pkg::res_t p_r   [1:W];

  for (genvar j = 0; j < W; j++) begin : g_stg
    mbf_pkg::ctl_t c_s;
    mbf_pkg::res_t q_s, aux_s, x_s, y_s, p_s;
    if (j == 0) begin : g_first
      assign c_s   = ctl_i;
      assign q_s   = q_i;
      assign aux_s = aux_i;
      assign x_s   = x_i;
      assign y_s   = y_i;
      assign p_s   = '0;
    end else begin : g_mid
      assign c_s   = ctl_r[j];
      assign q_s   = q_r[j];
      assign aux_s = aux_r[j];
      assign x_s   = x_r[j];
      assign y_s   = y_r[j];
      assign p_s   = p_r[j];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[j+1] <= '0;
      end else begin
        ctl_r[j+1] <= c_s;
      end
      q_r[j+1]   <= q_s;
      aux_r[j+1] <= aux_s;
      x_r[j+1]   <= x_s;
      y_r[j+1]   <= y_s;
      p_r[j+1]   <= mbf_pkg::dbl_add(p_s, y_s[W-1-j], x_s, q_s);
    end
  end

  assign ctl_o = ctl_r[W];
  assign q_o   = q_r[W];
  assign aux_o = aux_r[W];
  assign p_o   = p_r[W];

endmodule
`default_nettype wire

>>> sv/modular_butterfly_by_fourth_root.sv
// ----------------------------------------------------------------------------
// modular_butterfly_by_fourth_root
// Forward / inverse radix-2 butterfly by a fourth root of unity mod q.
//
//   channel  ports                                         handshake
//   input    in_req_type in_low in_high in_last_in_batch   start & !busy
//   result   out_low out_high out_batch_end                out_valid strobe
//   config   cfg_index cfg_data                            cfg_we
//
// One item per cycle; the path is input register, 62 remainder
// stages, operand prep, 62 multiply stages, output register.
// Synchronous reset clears all valid bits; busy is high only in reset.
// Results are never stalled.
// ----------------------------------------------------------------------------
`default_nettype none
module modular_butterfly_by_fourth_root (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 in_req_type,
  input  wire logic [mbf_pkg::W-1:0] in_low,
  input  wire logic [mbf_pkg::W-1:0] in_high,
  input  wire logic                 in_last_in_batch,
  output logic                      out_valid,
  output logic [mbf_pkg::W-1:0]     out_low,
  output logic [mbf_pkg::W-1:0]     out_high,
  output logic                      out_batch_end,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [mbf_pkg::W-1:0] cfg_data
);

  localparam int W = mbf_pkg::W;

  mbf_pkg::res_t mod_r, imag_r, half_r;
  mbf_pkg::ctl_t ctl0_r;
  mbf_pkg::res_t q0_r, a0_r, b0_r, k0_r;

  mbf_pkg::ctl_t rctl;
  mbf_pkg::res_t rq, ra, rb, rk;

  mbf_pkg::ctl_t ctlp_r;
  mbf_pkg::res_t qp_r, auxp_r, xp_r, yp_r;

  mbf_pkg::ctl_t mctl;
  mbf_pkg::res_t mq, maux, mp;

  logic          vld_r;
  mbf_pkg::res_t lo_r, hi_r;
  logic          be_r;
  mbf_pkg::res_t lo_nxt, hi_nxt;
  logic [W:0]    hsum;
  mbf_pkg::res_t half;

  assign busy = ~rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r  <= 62'd5;
      imag_r <= 62'd2;
      half_r <= 62'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        mbf_pkg::RegModulus: mod_r  <= cfg_data;
        mbf_pkg::RegImag:    imag_r <= cfg_data;
        mbf_pkg::RegHalf:    half_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
    end else begin
      ctl0_r.vld  <= start & ~busy;
      ctl0_r.inv  <= in_req_type;
      ctl0_r.last <= in_last_in_batch;
    end
    q0_r <= mod_r;
    a0_r <= in_low;
    b0_r <= in_high;
    k0_r <= in_req_type ? half_r : imag_r;
  end

  mbf_reduce u_reduce (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (ctl0_r),
    .q_i   (q0_r),
    .a_i   (a0_r),
    .b_i   (b0_r),
    .k_i   (k0_r),
    .ctl_o (rctl),
    .q_o   (rq),
    .a_o   (ra),
    .b_o   (rb),
    .k_o   (rk)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctlp_r <= '0;
    end else begin
      ctlp_r <= rctl;
    end
    qp_r   <= rq;
    auxp_r <= rctl.inv ? mbf_pkg::add_mod(ra, rb, rq) : ra;
    xp_r   <= rctl.inv ? mbf_pkg::sub_mod(ra, rb, rq) : rb;
    yp_r   <= rk;
  end

  mbf_mulmod u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (ctlp_r),
    .q_i   (qp_r),
    .aux_i (auxp_r),
    .x_i   (xp_r),
    .y_i   (yp_r),
    .ctl_o (mctl),
    .q_o   (mq),
    .aux_o (maux),
    .p_o   (mp)
  );

  always_comb begin
    hsum = {1'b0, maux} + (maux[0] ? {1'b0, mq} : '0);
    half = hsum[W:1];
    if (mq == '0) begin
      lo_nxt = '0;
      hi_nxt = '0;
    end else if (mctl.inv) begin
      lo_nxt = (half >= mq) ? half - mq : half;
      hi_nxt = mp;
    end else begin
      lo_nxt = mbf_pkg::add_mod(maux, mp, mq);
      hi_nxt = mbf_pkg::sub_mod(maux, mp, mq);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= mctl.vld;
    end
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    be_r <= mctl.last;
  end

  assign out_valid     = vld_r;
  assign out_low       = lo_r;
  assign out_high      = hi_r;
  assign out_batch_end = be_r;

endmodule
`default_nettype wire

>>> sv/mbf_checker.sv
// ----------------------------------------------------------------------------
// mbf_checker
// Port-level checks: busy only in reset, no result right after reset, fixed latency and batch mark alignment.
// ----------------------------------------------------------------------------
`default_nettype none
module mbf_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic in_last_in_batch,
  input wire logic out_valid,
  input wire logic out_batch_end
);

  logic acc;
  assign acc = start & ~busy;

  a_busy: assert property (@(posedge clk) busy == !rst_n)
    else $error("busy outside reset");

  a_rst_quiet: assert property (@(posedge clk) rst_n && !$past(rst_n) |-> !out_valid)
    else $error("result right after reset");

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc, mbf_pkg::Lat))
    else $error("result without matching item");

  a_mark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_batch_end == $past(in_last_in_batch, mbf_pkg::Lat))
    else $error("batch mark misaligned");

endmodule

bind modular_butterfly_by_fourth_root mbf_checker u_mbf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_last_in_batch (in_last_in_batch),
  .out_valid        (out_valid),
  .out_batch_end    (out_batch_end)
);
`default_nettype wire
